/* rtl/glyph_pixel_format_converter_assert.svh */
// ----------------------------------------------------------------------------
// glyph_pixel_format_converter_assert.svh
// Assertion macros shared by the converter RTL. They are clocked on clock
// and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef GLYPH_PIXEL_FORMAT_CONVERTER_ASSERT_SVH
`define GLYPH_PIXEL_FORMAT_CONVERTER_ASSERT_SVH

// same-cycle implication
`define GPFC_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gpfc assertion failed");

// next-cycle implication
`define GPFC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gpfc assertion failed");

`endif

/* rtl/gpfc_pkg.sv */
// ----------------------------------------------------------------------------
// gpfc_pkg
// Beat types, mode codes and divider state for the glyph pixel converter.
// ----------------------------------------------------------------------------
package gpfc_pkg;

   localparam logic [1:0] MODE_GRAY   = 2'd0;
   localparam logic [1:0] MODE_MONO   = 2'd1;
   localparam logic [1:0] MODE_SUBPIX = 2'd2;
   localparam logic [1:0] MODE_COLOR  = 2'd3;

   localparam int unsigned MONO_MAX_PIXELS     = 8;
   localparam int unsigned DIV_STEPS_PER_STAGE = 4;
   localparam int unsigned NUM_CHANNELS        = 3;

   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [7:0] byte3;
      logic [3:0] valid_bits;
      logic       row_end;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last;
      logic       row_done;
   } rsp_type;

   // long division state: partial remainder, numerator bits not yet
   // brought down, quotient bits so far
   typedef struct packed {
      logic [7:0] rem;
      logic [7:0] num;
      logic [7:0] quo;
   } div_state_type;

endpackage

/* rtl/gpfc_div_step.sv */
// ----------------------------------------------------------------------------
// gpfc_div_step
// Restoring divide slice: brings down DIV_STEPS_PER_STAGE numerator bits
// against an 8-bit divisor and develops one quotient bit for each.
// ----------------------------------------------------------------------------
module gpfc_div_step
   import gpfc_pkg::*;
(
   input  logic [7:0]    divisor,
   input  div_state_type state_in,
   output div_state_type state_out
);

   always_comb begin
      div_state_type st;
      logic [8:0]    trial;
      st    = state_in;
      trial = '0;
      for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
         trial = {st.rem, st.num[7]};
         // remainder stays below the divisor when it starts below it, so it then fits 8 bits
         if (trial >= {1'b0, divisor}) begin
            st.rem = 8'(trial - {1'b0, divisor});
            st.quo = {st.quo[6:0], 1'b1};
         end else begin
            st.rem = trial[7:0];
            st.quo = {st.quo[6:0], 1'b0};
         end
         st.num = {st.num[6:0], 1'b0};
      end
      state_out = st;
   end

endmodule

/* rtl/glyph_pixel_format_converter.sv */
// ----------------------------------------------------------------------------
// glyph_pixel_format_converter
// Converts glyph pixel data to straight RGBA under the pixel mode register.
// ----------------------------------------------------------------------------
// A new req beat is taken every cycle while the output drains. From req
// acceptance to the first rsp beat, one stage forms the c*255 + alpha/2
// numerators and the subpixel maximum, two stages each run four steps of the
// restoring divider for all three colour channels, and the output register
// assembles the pixel. Gray, subpixel and colour items give one rsp beat each,
// so the block sustains one pixel per clock while the output drains. A mono
// item gives valid_bits beats (eight at most, larger counts act as eight) and
// holds the output register until its last beat is taken; a mono item with
// valid_bits zero is dropped at entry. The mode register may only be written
// while the block is empty; csr_ready is always high.
// ----------------------------------------------------------------------------
module glyph_pixel_format_converter
   import gpfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_pixel_mode,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

`include "glyph_pixel_format_converter_assert.svh"

   logic [1:0] mode_ff;

   // stage 1
   logic          s1_valid_ff;
   logic [1:0]    s1_mode_ff;
   req_type       s1_req_ff;
   logic [7:0]    s1_max_ff;
   logic [15:0]   s1_num_ff [NUM_CHANNELS];
   // stage 2
   logic          s2_valid_ff;
   logic [1:0]    s2_mode_ff;
   req_type       s2_req_ff;
   logic [7:0]    s2_max_ff;
   logic          s2_sat_ff [NUM_CHANNELS];
   div_state_type s2_div_ff [NUM_CHANNELS];
   div_state_type s2_div_in [NUM_CHANNELS];
   div_state_type s2_init   [NUM_CHANNELS];
   // stage 3
   logic          s3_valid_ff;
   logic [1:0]    s3_mode_ff;
   req_type       s3_req_ff;
   logic [7:0]    s3_max_ff;
   logic          s3_sat_ff [NUM_CHANNELS];
   div_state_type s3_div_ff [NUM_CHANNELS];
   div_state_type s3_div_in [NUM_CHANNELS];
   // output register
   logic          out_valid_ff;
   rsp_type       rsp_ff;
   logic [7:0]    bits_ff;
   logic [3:0]    cnt_ff;
   logic          row_end_ff;

   logic          out_take;
   logic          s1_en;
   logic          s2_en;
   logic          s3_en;
   logic          drop;
   req_type       req_clamped;
   logic [7:0]    max_in;
   logic [15:0]   num_in [NUM_CHANNELS];
   logic [7:0]    chan_src [NUM_CHANNELS];
   logic [7:0]    chan_val [NUM_CHANNELS];
   rsp_type       load_rsp;
   logic [3:0]    load_cnt;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_GRAY;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_pixel_mode;
      end
   end

   // ---- handshake chain ----
   assign out_take  = !out_valid_ff || (rsp_ready && cnt_ff == 4'd1);
   assign s3_en     = !s3_valid_ff || out_take;
   assign s2_en     = !s2_valid_ff || s3_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_ready = s1_en;

   // ---- stage 1: numerators and subpixel max ----
   always_comb begin
      req_clamped = req_data;
      if (req_data.valid_bits > 4'(MONO_MAX_PIXELS)) begin
         req_clamped.valid_bits = 4'(MONO_MAX_PIXELS);
      end
      drop = (mode_ff == MODE_MONO) && (req_data.valid_bits == 4'd0);
      max_in = (req_data.byte0 > req_data.byte1) ? req_data.byte0 : req_data.byte1;
      if (req_data.byte2 > max_in) begin
         max_in = req_data.byte2;
      end
   end

   assign chan_src[0] = req_data.byte0;
   assign chan_src[1] = req_data.byte1;
   assign chan_src[2] = req_data.byte2;

   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_num
      // c*255 + alpha/2, at most 65152
      assign num_in[c] = {chan_src[c], 8'h00} - {8'h00, chan_src[c]}
                       + {9'h000, req_data.byte3[7:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_valid && !drop;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_mode_ff <= mode_ff;
         s1_req_ff  <= req_clamped;
         s1_max_ff  <= max_in;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            s1_num_ff[c] <= num_in[c];
         end
      end
   end

   // ---- stages 2 and 3: divider ----
   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_div
      assign s2_init[c] = '{rem: s1_num_ff[c][15:8], num: s1_num_ff[c][7:0], quo: 8'h00};

      gpfc_div_step u_div_hi (
         .divisor   (s1_req_ff.byte3),
         .state_in  (s2_init[c]),
         .state_out (s2_div_in[c])
      );

      gpfc_div_step u_div_lo (
         .divisor   (s2_req_ff.byte3),
         .state_in  (s2_div_ff[c]),
         .state_out (s3_div_in[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_en) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_mode_ff <= s1_mode_ff;
         s2_req_ff  <= s1_req_ff;
         s2_max_ff  <= s1_max_ff;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            // quotient of 256 or more when the top byte reaches alpha
            s2_sat_ff[c] <= s1_num_ff[c][15:8] >= s1_req_ff.byte3;
            s2_div_ff[c] <= s2_div_in[c];
         end
      end
      if (s3_en) begin
         s3_mode_ff <= s2_mode_ff;
         s3_req_ff  <= s2_req_ff;
         s3_max_ff  <= s2_max_ff;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            s3_sat_ff[c] <= s2_sat_ff[c];
            s3_div_ff[c] <= s3_div_in[c];
         end
      end
   end

   // ---- output assembly ----
   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
      assign chan_val[c] = (s3_req_ff.byte3 == 8'h00) ? 8'h00 :
                           s3_sat_ff[c]                ? 8'hFF : s3_div_ff[c].quo;
   end

   always_comb begin
      load_rsp          = '0;
      load_rsp.last     = 1'b1;
      load_rsp.row_done = s3_req_ff.row_end;
      load_cnt          = 4'd1;
      case (s3_mode_ff)
         MODE_GRAY: begin
            load_rsp.alpha = s3_req_ff.byte0;
         end
         MODE_MONO: begin
            load_cnt          = s3_req_ff.valid_bits;
            load_rsp.alpha    = s3_req_ff.byte0[7] ? 8'hFF : 8'h00;
            load_rsp.last     = s3_req_ff.valid_bits == 4'd1;
            load_rsp.row_done = (s3_req_ff.valid_bits == 4'd1) && s3_req_ff.row_end;
         end
         MODE_SUBPIX: begin
            load_rsp.red   = s3_req_ff.byte0;
            load_rsp.green = s3_req_ff.byte1;
            load_rsp.blue  = s3_req_ff.byte2;
            load_rsp.alpha = s3_max_ff;
         end
         MODE_COLOR: begin
            load_rsp.red   = chan_val[2];
            load_rsp.green = chan_val[1];
            load_rsp.blue  = chan_val[0];
            load_rsp.alpha = s3_req_ff.byte3;
         end
         default: begin
            load_rsp.alpha = s3_req_ff.byte0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         cnt_ff       <= 4'd0;
      end else if (out_take) begin
         out_valid_ff <= s3_valid_ff;
         cnt_ff       <= s3_valid_ff ? load_cnt : 4'd0;
      end else if (rsp_ready) begin
         // mid-item mono beat taken
         cnt_ff <= cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         rsp_ff     <= load_rsp;
         bits_ff    <= s3_req_ff.byte0;
         row_end_ff <= s3_req_ff.row_end;
      end else if (rsp_ready) begin
         bits_ff         <= {bits_ff[6:0], 1'b0};
         rsp_ff.alpha    <= bits_ff[6] ? 8'hFF : 8'h00;
         rsp_ff.last     <= cnt_ff == 4'd2;
         rsp_ff.row_done <= (cnt_ff == 4'd2) && row_end_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---- checks ----
   `GPFC_ASSERT_IMPLIES(a_out_count_live, out_valid_ff, cnt_ff != 4'd0)
   `GPFC_ASSERT_IMPLIES(a_last_matches_count, rsp_valid, rsp_data.last == (cnt_ff == 4'd1))
   `GPFC_ASSERT_IMPLIES(a_row_done_on_last, rsp_valid && rsp_data.row_done, rsp_data.last)
   `GPFC_ASSERT_NEXT(a_mono_continues, rsp_valid && rsp_ready && !rsp_data.last, rsp_valid)
   `GPFC_ASSERT_NEXT(a_s3_holds, s3_valid_ff && !s3_en, s3_valid_ff)

endmodule
